// File: rtl/dwsr_pkg.sv
// Package with types, constants and helpers shared by the route finder modules.
`timescale 1ns / 1ps
package dwsr_pkg;

  localparam int MAX_NODES   = 16;
  localparam int MAX_EDGES   = 32;
  localparam int WEIGHT_BITS = 16;
  localparam int TOTAL_BITS  = 24;
  localparam int NODE_BITS   = 4;
  localparam int EDGE_IDX_BITS = $clog2(MAX_EDGES);
  localparam int EDGE_CNT_BITS = $clog2(MAX_EDGES + 1);
  localparam int OCC_BITS    = $clog2(MAX_NODES + 1);

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  localparam logic [3:0] NODE_COUNT_RESET = 4'd8;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  end_a;
    logic [3:0]  end_b;
    logic        air_present;
    logic [15:0] air_time;
    logic [15:0] air_cost;
    logic        road_present;
    logic [15:0] road_time;
    logic [15:0] road_cost;
    logic [3:0]  source;
    logic [3:0]  destination;
    logic        mode;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        reachable;
    logic [23:0] primary_total;
    logic [23:0] secondary_total;
    logic [3:0]  path_node;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [NODE_BITS-1:0]   end_a;
    logic [NODE_BITS-1:0]   end_b;
    logic                   air_present;
    logic                   road_present;
    logic [WEIGHT_BITS-1:0] air_time;
    logic [WEIGHT_BITS-1:0] air_cost;
    logic [WEIGHT_BITS-1:0] road_time;
    logic [WEIGHT_BITS-1:0] road_cost;
  } edge_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_CLEAR, S_QCHK, S_QINIT, S_POP, S_LOADU, S_EREAD,
    S_EEVAL, S_RELAX, S_FIN, S_WALK, S_RDDST, S_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic add;
    logic clear;
    logic emit_none;
    logic init;
    logic pop;
    logic load_u;
    logic eread;
    logic eval;
    logic relax;
    logic walk_init;
    logic walk;
    logic rd_dst;
    logic emit_path;
  } dp_cmd_t;

  typedef struct packed {
    logic q_bad;
    logic fifo_empty;
    logic no_edges;
    logic edge_last;
    logic dst_reached;
    logic walk_done;
    logic emit_last;
  } dp_status_t;

  function automatic logic [TOTAL_BITS-1:0] sat_add(input logic [TOTAL_BITS-1:0] a,
                                                    input logic [TOTAL_BITS-1:0] b);
    logic [TOTAL_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOTAL_BITS] ? TOTAL_MAX : s[TOTAL_BITS-1:0];
  endfunction

endpackage

// File: rtl/dual_weight_spfa_route_finder_unit.sv
// Add and clear pass through the S_ADD or S_CLEAR state, and the result strobe is registered
// from that state; a new item is accepted only while busy is low, not while one is in flight.
// A query pops each work queue node (S_POP, S_LOADU), reads, evaluates and relaxes each of
// its stored edges, then walks the path, reads the totals and emits one result per path node.
// Results cannot be stalled; busy falls in the cycle that carries the last result.
// Reset clears the edge count, the work queue and its flags, and sets node_count to 8.
`timescale 1ns / 1ps
module dual_weight_spfa_route_finder_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  dwsr_pkg::in_item_t item,
  input  logic               wr_en,
  input  logic [3:0]         wr_data,
  output logic               result_valid,
  output dwsr_pkg::result_t  result
);

  dwsr_pkg::dp_cmd_t    cmd;
  dwsr_pkg::dp_status_t stat;

  dwsr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (item.command),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  dwsr_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .wr_en        (wr_en),
    .wr_data      (wr_data),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// File: rtl/dwsr_ctrl.sv
// Controller state machine that sequences edge loads and route searches.
`timescale 1ns / 1ps
module dwsr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [1:0]           command,
  input  dwsr_pkg::dp_status_t stat,
  output dwsr_pkg::dp_cmd_t    cmd,
  output logic                 busy
);

  dwsr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dwsr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dwsr_pkg::S_IDLE: begin
        if (start) begin
          case (command)
            dwsr_pkg::CMD_ADD:   state_next = dwsr_pkg::S_ADD;
            dwsr_pkg::CMD_QUERY: state_next = dwsr_pkg::S_QCHK;
            dwsr_pkg::CMD_CLEAR: state_next = dwsr_pkg::S_CLEAR;
            default:             state_next = dwsr_pkg::S_IDLE;
          endcase
        end
      end
      dwsr_pkg::S_ADD:   state_next = dwsr_pkg::S_IDLE;
      dwsr_pkg::S_CLEAR: state_next = dwsr_pkg::S_IDLE;
      dwsr_pkg::S_QCHK:  state_next = stat.q_bad ? dwsr_pkg::S_IDLE : dwsr_pkg::S_QINIT;
      dwsr_pkg::S_QINIT: state_next = dwsr_pkg::S_POP;
      dwsr_pkg::S_POP:   state_next = stat.fifo_empty ? dwsr_pkg::S_FIN : dwsr_pkg::S_LOADU;
      dwsr_pkg::S_LOADU: state_next = stat.no_edges ? dwsr_pkg::S_POP : dwsr_pkg::S_EREAD;
      dwsr_pkg::S_EREAD: state_next = dwsr_pkg::S_EEVAL;
      dwsr_pkg::S_EEVAL: state_next = dwsr_pkg::S_RELAX;
      dwsr_pkg::S_RELAX: state_next = stat.edge_last ? dwsr_pkg::S_POP : dwsr_pkg::S_EREAD;
      dwsr_pkg::S_FIN:   state_next = stat.dst_reached ? dwsr_pkg::S_WALK : dwsr_pkg::S_IDLE;
      dwsr_pkg::S_WALK:  state_next = stat.walk_done ? dwsr_pkg::S_RDDST : dwsr_pkg::S_WALK;
      dwsr_pkg::S_RDDST: state_next = dwsr_pkg::S_EMIT;
      dwsr_pkg::S_EMIT:  state_next = stat.emit_last ? dwsr_pkg::S_IDLE : dwsr_pkg::S_EMIT;
      default:           state_next = dwsr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      dwsr_pkg::S_IDLE:  cmd.capture = start;
      dwsr_pkg::S_ADD:   cmd.add = 1'b1;
      dwsr_pkg::S_CLEAR: cmd.clear = 1'b1;
      dwsr_pkg::S_QCHK:  cmd.emit_none = stat.q_bad;
      dwsr_pkg::S_QINIT: cmd.init = 1'b1;
      dwsr_pkg::S_POP:   cmd.pop = !stat.fifo_empty;
      dwsr_pkg::S_LOADU: cmd.load_u = 1'b1;
      dwsr_pkg::S_EREAD: cmd.eread = 1'b1;
      dwsr_pkg::S_EEVAL: cmd.eval = 1'b1;
      dwsr_pkg::S_RELAX: cmd.relax = 1'b1;
      dwsr_pkg::S_FIN: begin
        cmd.emit_none = !stat.dst_reached;
        cmd.walk_init = stat.dst_reached;
      end
      dwsr_pkg::S_WALK:  cmd.walk = 1'b1;
      dwsr_pkg::S_RDDST: cmd.rd_dst = 1'b1;
      dwsr_pkg::S_EMIT:  cmd.emit_path = 1'b1;
      default:           cmd = '0;
    endcase
  end

  assign busy = (state != dwsr_pkg::S_IDLE);

endmodule

// File: rtl/dwsr_datapath.sv
// Datapath with edge table, distance memory, work queue, path walk and result register.
`timescale 1ns / 1ps
module dwsr_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  dwsr_pkg::in_item_t   item,
  input  logic                 wr_en,
  input  logic [3:0]           wr_data,
  input  dwsr_pkg::dp_cmd_t    cmd,
  output dwsr_pkg::dp_status_t stat,
  output logic                 result_valid,
  output dwsr_pkg::result_t    result
);

  localparam int NB = dwsr_pkg::NODE_BITS;
  localparam int TB = dwsr_pkg::TOTAL_BITS;
  localparam int WB = dwsr_pkg::WEIGHT_BITS;
  localparam int MN = dwsr_pkg::MAX_NODES;

  logic [3:0] node_count;
  dwsr_pkg::in_item_t item_q;
  logic [dwsr_pkg::EDGE_CNT_BITS-1:0] edge_total;
  logic [dwsr_pkg::EDGE_CNT_BITS-1:0] e;
  dwsr_pkg::edge_t edge_mem [dwsr_pkg::MAX_EDGES];
  dwsr_pkg::edge_t edge_q;
  logic [TB-1:0] pdist [MN];
  logic [TB-1:0] sdist [MN];
  logic [TB-1:0] pd_rd, sd_rd;
  logic [NB-1:0] parent [MN];
  logic [NB-1:0] fifo [MN];
  logic [NB-1:0] path_buf [MN];
  logic [MN-1:0] reached, queued;
  logic [NB-1:0] head, tail, u, v_q, walk_node;
  logic [dwsr_pkg::OCC_BITS-1:0] occ;
  logic [NB:0] path_n;
  logic [TB-1:0] du, su;
  logic [WB-1:0] w_q, x_q;
  logic ok_q;

  logic [3:0] cnt;
  logic add_bad, add_full;
  logic q_bad;
  logic hit;
  logic [NB-1:0] v;
  logic [WB-1:0] ap_v, as_v, rp_v, rs_v, w, x;
  logic ok;
  logic rd_en;
  logic [NB-1:0] rd_addr;
  logic dw_en;
  logic [NB-1:0] dw_addr;
  logic [TB-1:0] dw_p, dw_s;
  logic [TB-1:0] cand;
  logic better, upd;
  dwsr_pkg::result_t result_next;

  assign cnt = node_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= dwsr_pkg::NODE_COUNT_RESET;
    end else if (wr_en) begin
      node_count <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q <= item;
    end
  end

  assign add_bad = (item_q.end_a == '0) || (item_q.end_b == '0) || (item_q.end_a > cnt) ||
                   (item_q.end_b > cnt) || (item_q.end_a == item_q.end_b) ||
                   !(item_q.air_present || item_q.road_present);
  assign add_full = (edge_total == dwsr_pkg::EDGE_CNT_BITS'(dwsr_pkg::MAX_EDGES));
  assign q_bad = (item_q.source == '0) || (item_q.destination == '0) ||
                 (item_q.source > cnt) || (item_q.destination > cnt);

  always_ff @(posedge clk) begin
    if (cmd.add && !add_bad && !add_full) begin
      edge_mem[edge_total[dwsr_pkg::EDGE_IDX_BITS-1:0]] <= '{
        end_a: item_q.end_a, end_b: item_q.end_b,
        air_present: item_q.air_present, road_present: item_q.road_present,
        air_time: item_q.air_time[WB-1:0], air_cost: item_q.air_cost[WB-1:0],
        road_time: item_q.road_time[WB-1:0], road_cost: item_q.road_cost[WB-1:0]};
    end
    if (cmd.eread) begin
      edge_q <= edge_mem[e[dwsr_pkg::EDGE_IDX_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_total <= '0;
    end else if (cmd.clear) begin
      edge_total <= '0;
    end else if (cmd.add && !add_bad && !add_full) begin
      edge_total <= edge_total + 1'b1;
    end
  end

  always_comb begin
    hit = 1'b1;
    v = edge_q.end_b;
    if (edge_q.end_a == u) begin
      v = edge_q.end_b;
    end else if (edge_q.end_b == u) begin
      v = edge_q.end_a;
    end else begin
      hit = 1'b0;
    end
    ap_v = item_q.mode ? edge_q.air_cost : edge_q.air_time;
    as_v = item_q.mode ? edge_q.air_time : edge_q.air_cost;
    rp_v = item_q.mode ? edge_q.road_cost : edge_q.road_time;
    rs_v = item_q.mode ? edge_q.road_time : edge_q.road_cost;
    if (edge_q.air_present && edge_q.road_present) begin
      w = (rp_v < ap_v) ? rp_v : ap_v;
      x = (rs_v > as_v) ? rs_v : as_v;
    end else if (edge_q.air_present) begin
      w = ap_v;
      x = as_v;
    end else begin
      w = rp_v;
      x = rs_v;
    end
    ok = hit && (v != '0) && (v <= cnt) && (edge_q.air_present || edge_q.road_present);
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      v_q <= v;
      w_q <= w;
      x_q <= x;
      ok_q <= ok;
    end
  end

  always_comb begin
    rd_en = cmd.pop || cmd.eval || cmd.rd_dst;
    rd_addr = item_q.destination;
    if (cmd.pop) begin
      rd_addr = fifo[head];
    end else if (cmd.eval) begin
      rd_addr = v;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      pd_rd <= pdist[rd_addr];
      sd_rd <= sdist[rd_addr];
    end
  end

  assign cand = dwsr_pkg::sat_add(du, TB'(w_q));
  assign better = !reached[v_q] || (pd_rd > cand);
  assign upd = cmd.relax && ok_q && better;

  always_comb begin
    dw_en = cmd.init || upd;
    dw_addr = cmd.init ? item_q.source : v_q;
    dw_p = cmd.init ? '0 : cand;
    dw_s = cmd.init ? '0 : dwsr_pkg::sat_add(su, TB'(x_q));
  end

  always_ff @(posedge clk) begin
    if (dw_en) begin
      pdist[dw_addr] <= dw_p;
      sdist[dw_addr] <= dw_s;
      parent[dw_addr] <= cmd.init ? '0 : u;
    end
    if (cmd.init) begin
      fifo[0] <= item_q.source;
    end else if (upd && !queued[v_q] && (occ < dwsr_pkg::OCC_BITS'(MN))) begin
      fifo[tail] <= v_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reached <= '0;
      queued <= '0;
      head <= '0;
      tail <= '0;
      occ <= '0;
    end else if (cmd.init) begin
      reached <= MN'(1) << item_q.source;
      queued <= MN'(1) << item_q.source;
      head <= '0;
      tail <= NB'(1);
      occ <= dwsr_pkg::OCC_BITS'(1);
    end else if (cmd.pop) begin
      head <= head + 1'b1;
      occ <= occ - 1'b1;
      queued[fifo[head]] <= 1'b0;
    end else if (upd) begin
      reached[v_q] <= 1'b1;
      if (!queued[v_q] && (occ < dwsr_pkg::OCC_BITS'(MN))) begin
        queued[v_q] <= 1'b1;
        tail <= tail + 1'b1;
        occ <= occ + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      u <= fifo[head];
    end
    if (cmd.load_u) begin
      du <= pd_rd;
      su <= sd_rd;
      e <= '0;
    end else if (cmd.relax) begin
      e <= e + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      walk_node <= item_q.destination;
      path_n <= '0;
    end else if (cmd.walk) begin
      path_buf[path_n[NB-1:0]] <= walk_node;
      path_n <= path_n + 1'b1;
      walk_node <= parent[walk_node];
    end else if (cmd.emit_path) begin
      path_n <= path_n - 1'b1;
    end
  end

  assign stat.q_bad = q_bad;
  assign stat.fifo_empty = (occ == '0);
  assign stat.no_edges = (edge_total == '0);
  assign stat.edge_last = ((e + 1'b1) >= edge_total);
  assign stat.dst_reached = reached[item_q.destination];
  assign stat.walk_done = (walk_node == item_q.source) || ((path_n + 1'b1) >= {1'b0, cnt});
  assign stat.emit_last = (path_n == (NB+1)'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.add || cmd.clear || cmd.emit_none || cmd.emit_path;
    end
  end

  always_comb begin
    result_next = '0;
    result_next.last = 1'b1;
    if (cmd.add) begin
      result_next.status = add_bad ? dwsr_pkg::ST_BAD :
                           (add_full ? dwsr_pkg::ST_FULL : dwsr_pkg::ST_OK);
    end else if (cmd.emit_path) begin
      result_next.reachable = 1'b1;
      result_next.primary_total = 24'(pd_rd);
      result_next.secondary_total = 24'(sd_rd);
      result_next.path_node = path_buf[path_n[NB-1:0] - 1'b1];
      result_next.last = (path_n == (NB+1)'(1));
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule
